/* src/assert_macros.svh */
// Assertion macros shared by the job queue RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// ante holds in a cycle -> cons holds in the same cycle
`define CJQ_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
// ante holds in a cycle -> cons holds in the next cycle
`define CJQ_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define CJQ_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define CJQ_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

/* src/cjq_pkg.sv */
// Package for the circular job queue: payload types, codes and defaults.
// No dependencies; used by the top level.
`default_nettype none

package cjq_pkg;

	localparam int DEPTH_DEF  = 16;
	localparam int TAG_W      = 64;
	localparam int PAGES_W    = 10;
	localparam int ENTRY_W    = TAG_W + PAGES_W;
	localparam int PADDR_W    = 3;
	localparam int PDATA_W    = 32;

	localparam logic [PAGES_W-1:0] MAX_PAGES_RESET = 10'd50;

	// request kinds
	localparam logic [1:0] KIND_ENQ    = 2'd0;
	localparam logic [1:0] KIND_DEQ    = 2'd1;
	localparam logic [1:0] KIND_CANCEL = 2'd2;
	localparam logic [1:0] KIND_CLEAR  = 2'd3;

	// result status codes
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_PAGES    = 3'd1;
	localparam logic [2:0] ST_FULL     = 3'd2;
	localparam logic [2:0] ST_EMPTY    = 3'd3;
	localparam logic [2:0] ST_NOTFOUND = 3'd4;

	// register index of max_pages (word address paddr[2])
	localparam logic REG_MAX_PAGES = 1'b0;

	typedef struct packed {
		logic [1:0]         kind;
		logic [TAG_W-1:0]   name_tag;
		logic [PAGES_W-1:0] page_count;
	} req_t;

	typedef struct packed {
		logic [2:0]         status;
		logic [TAG_W-1:0]   out_tag;
		logic [PAGES_W-1:0] out_pages;
		logic [3:0]         occupancy;
	} rsp_t;

endpackage

`default_nettype wire

/* src/cjq_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies; holds the job store of the queue.
`default_nettype none

module cjq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

/* src/circular_job_queue_with_cancel.sv */
// Ring-buffer job queue with cancel by tag; top level.
// Depends on cjq_pkg, cjq_ram and assert_macros.svh.
//
// Holds up to DEPTH-1 jobs (64-bit tag, 10-bit page count) in one RAM that is
// read one slot per cycle. Enqueue, clear, a rejected enqueue and a request on
// an empty queue load their result as they are taken; a dequeue reads the head
// slot and loads it into the result in state S_DEQ. A cancel reads the slots
// from the head until the tag matches, then moves every later job up one slot,
// one slot per cycle. The job store has a single read port. A new request is
// taken once the block is idle and its result register is empty or being taken
// in the same cycle.
`default_nettype none

module circular_job_queue_with_cancel #(
	parameter int DEPTH = cjq_pkg::DEPTH_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	// request channel
	input  wire logic                         req_valid,
	output logic                              req_stall,
	input  wire cjq_pkg::req_t                req_data,
	// result channel
	output logic                              rsp_valid,
	input  wire logic                         rsp_stall,
	output cjq_pkg::rsp_t                     rsp_data,
	// configuration port
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [cjq_pkg::PADDR_W-1:0]  paddr,
	input  wire logic [cjq_pkg::PDATA_W-1:0]  pwdata,
	output logic      [cjq_pkg::PDATA_W-1:0]  prdata,
	output logic                              pready
);

	localparam int IW = $clog2(DEPTH);
	localparam logic [IW-1:0] LAST = IW'(DEPTH - 1);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_DEQ   = 2'd1;
	localparam logic [1:0] S_SRCH  = 2'd2;
	localparam logic [1:0] S_SHIFT = 2'd3;

	function automatic logic [IW-1:0] ring_next(input logic [IW-1:0] i);
		return (i == LAST) ? '0 : i + 1'b1;
	endfunction

	function automatic logic [IW-1:0] ring_prev(input logic [IW-1:0] i);
		return (i == '0) ? LAST : i - 1'b1;
	endfunction

	function automatic logic [IW-1:0] ring_count(input logic [IW-1:0] h,
		input logic [IW-1:0] t);
		logic [IW:0] wrap;
		wrap = {1'b0, t} + (IW+1)'(DEPTH) - {1'b0, h};
		return (t >= h) ? (t - h) : wrap[IW-1:0];
	endfunction

	logic [1:0]                    state_q, state_d;
	logic [IW-1:0]                 head_q, head_d;
	logic [IW-1:0]                 tail_q, tail_d;
	logic [IW-1:0]                 idx_q, idx_d;
	logic [cjq_pkg::TAG_W-1:0]     key_q, key_d;
	logic [cjq_pkg::PAGES_W-1:0]   max_pages_q;
	logic                          rsp_valid_q;
	cjq_pkg::rsp_t                 rsp_q;

	logic                          accept;
	logic                          load;
	logic [2:0]                    st;
	logic [cjq_pkg::TAG_W-1:0]     otag;
	logic [cjq_pkg::PAGES_W-1:0]   opages;
	logic [IW-1:0]                 nx;
	logic [IW-1:0]                 nx2;

	logic                          ram_we;
	logic [IW-1:0]                 ram_waddr;
	logic [cjq_pkg::ENTRY_W-1:0]   ram_wdata;
	logic                          ram_re;
	logic [IW-1:0]                 ram_raddr;
	logic [cjq_pkg::ENTRY_W-1:0]   ram_rdata;
	logic [cjq_pkg::TAG_W-1:0]     rd_tag;
	logic [cjq_pkg::PAGES_W-1:0]   rd_pages;

	assign rd_tag   = ram_rdata[cjq_pkg::ENTRY_W-1:cjq_pkg::PAGES_W];
	assign rd_pages = ram_rdata[cjq_pkg::PAGES_W-1:0];

	// job store
	cjq_ram #(
		.WIDTH(cjq_pkg::ENTRY_W),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// handshake
	assign req_stall = !((state_q == S_IDLE) && (!rsp_valid_q || !rsp_stall));
	assign accept    = req_valid && !req_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

	// configuration port
	assign pready = 1'b1;
	assign prdata = (paddr[2] == cjq_pkg::REG_MAX_PAGES) ?
		cjq_pkg::PDATA_W'(max_pages_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_pages_q <= cjq_pkg::MAX_PAGES_RESET;
		end else if (psel && penable && pwrite && pready
			&& (paddr[2] == cjq_pkg::REG_MAX_PAGES)) begin
			max_pages_q <= pwdata[cjq_pkg::PAGES_W-1:0];
		end
	end

	// sequencer: read, compare, shift and write back through the store
	always_comb begin
		state_d   = state_q;
		head_d    = head_q;
		tail_d    = tail_q;
		idx_d     = idx_q;
		key_d     = key_q;
		load      = 1'b0;
		st        = cjq_pkg::ST_OK;
		otag      = '0;
		opages    = '0;
		ram_we    = 1'b0;
		ram_waddr = tail_q;
		ram_wdata = {req_data.name_tag, req_data.page_count};
		ram_re    = 1'b0;
		ram_raddr = head_q;
		nx        = ring_next(idx_q);
		nx2       = ring_next(nx);

		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (req_data.kind)
						cjq_pkg::KIND_ENQ: begin
							load = 1'b1;
							if (req_data.page_count > max_pages_q) begin
								st = cjq_pkg::ST_PAGES;
							end else if (ring_next(tail_q) == head_q) begin
								st = cjq_pkg::ST_FULL;
							end else begin
								ram_we = 1'b1;
								tail_d = ring_next(tail_q);
							end
						end
						cjq_pkg::KIND_DEQ: begin
							if (head_q == tail_q) begin
								load = 1'b1;
								st   = cjq_pkg::ST_EMPTY;
							end else begin
								ram_re  = 1'b1;
								state_d = S_DEQ;
							end
						end
						cjq_pkg::KIND_CANCEL: begin
							if (head_q == tail_q) begin
								load = 1'b1;
								st   = cjq_pkg::ST_EMPTY;
							end else begin
								ram_re  = 1'b1;
								idx_d   = head_q;
								key_d   = req_data.name_tag;
								state_d = S_SRCH;
							end
						end
						cjq_pkg::KIND_CLEAR: begin
							load   = 1'b1;
							head_d = '0;
							tail_d = '0;
						end
						default: begin
							load = 1'b1;
						end
					endcase
				end
			end
			S_DEQ: begin
				load    = 1'b1;
				otag    = rd_tag;
				opages  = rd_pages;
				head_d  = ring_next(head_q);
				state_d = S_IDLE;
			end
			S_SRCH: begin
				// rdata holds slot idx_q
				if (rd_tag == key_q) begin
					if (nx == tail_q) begin
						load    = 1'b1;
						tail_d  = ring_prev(tail_q);
						state_d = S_IDLE;
					end else begin
						ram_re    = 1'b1;
						ram_raddr = nx;
						state_d   = S_SHIFT;
					end
				end else if (nx == tail_q) begin
					load    = 1'b1;
					st      = cjq_pkg::ST_NOTFOUND;
					state_d = S_IDLE;
				end else begin
					ram_re    = 1'b1;
					ram_raddr = nx;
					idx_d     = nx;
				end
			end
			S_SHIFT: begin
				// rdata holds slot after idx_q; move it up into idx_q
				ram_we    = 1'b1;
				ram_waddr = idx_q;
				ram_wdata = ram_rdata;
				idx_d     = nx;
				if (nx2 == tail_q) begin
					load    = 1'b1;
					tail_d  = ring_prev(tail_q);
					state_d = S_IDLE;
				end else begin
					ram_re    = 1'b1;
					ram_raddr = nx2;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q  <= '0;
			tail_q  <= '0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			tail_q  <= tail_d;
		end
	end

	// search position and key
	always_ff @(posedge clk) begin
		idx_q <= idx_d;
		key_q <= key_d;
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_valid_q && !rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rsp_q.status    <= st;
			rsp_q.out_tag   <= otag;
			rsp_q.out_pages <= opages;
			rsp_q.occupancy <= 4'(ring_count(head_d, tail_d));
		end
	end

	`include "assert_macros.svh"

	`CJQ_ASSERT_IMP(a_accept_idle, clk, arst_n, accept, state_q == S_IDLE, "request taken while busy")
	`CJQ_ASSERT_IMP(a_busy_no_rsp, clk, arst_n, state_q != S_IDLE, !rsp_valid_q, "result pending during multi-cycle work")
	`CJQ_ASSERT_IMP(a_cancel_nonempty, clk, arst_n, state_q == S_SRCH || state_q == S_SHIFT, head_q != tail_q, "cancel running on empty queue")
	`CJQ_ASSERT_IMP(a_ram_no_collide, clk, arst_n, ram_we && ram_re, ram_waddr != ram_raddr, "store read and write hit same slot")
	`CJQ_ASSERT_NXT(a_work_ends, clk, arst_n, state_q == S_DEQ, state_q == S_IDLE && rsp_valid_q, "dequeue did not finish")

endmodule

`default_nettype wire
